// ===== hdl/hyperbolic_moveout_index_builder_core_defines.svh =====
// assertion macros for the moveout index builder
// they expect i_clk and i_rst_n in the scope where they are used
`ifndef HYPERBOLIC_MOVEOUT_INDEX_BUILDER_CORE_DEFINES_SVH
`define HYPERBOLIC_MOVEOUT_INDEX_BUILDER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define HMIB_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);
`define HMIB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define HMIB_ASSERT(lbl, expr, msg)
`define HMIB_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== hdl/hmib_pkg.sv =====
package hmib_pkg;

    // shift-add multiplier
    localparam int MUL_W = 32;

    // restoring divider: 64 bit dividend, 33 bit divisor
    localparam int DIV_N     = 64;
    localparam int DIV_D     = 33;
    localparam int DIV_CNT_W = 7;
    localparam logic [DIV_CNT_W-1:0] DIV_LONG_STEPS  = 7'd64;
    localparam logic [DIV_CNT_W-1:0] DIV_SHORT_STEPS = 7'd34;
    localparam int DIV_SHORT_SHIFT = 30;

    // square root: 64 bit radicand, 32 bit root
    localparam int SQRT_W = 32;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } t_div_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_BEFORE  = 2'd1,
        STAT_BEYOND  = 2'd2,
        STAT_INVALID = 2'd3
    } t_status;

    localparam logic [1:0] REG_SAMPLE_COUNT    = 2'd0;
    localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd1;
    localparam logic [1:0] REG_START_SAMPLE    = 2'd2;

endpackage

// ===== hdl/hmib_mul.sv =====
module hmib_mul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [hmib_pkg::MUL_W-1:0]   i_a,
    input  logic [hmib_pkg::MUL_W-1:0]   i_b,
    output logic                         o_done,
    output logic [2*hmib_pkg::MUL_W-1:0] o_product
);

    localparam int W   = hmib_pkg::MUL_W;
    localparam int CW  = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [2*W-1:0] r_prod;
    logic [W:0]    w_sum;

    // one multiplier bit per cycle, partial sum added into the upper half
    assign w_sum = {1'b0, r_prod[2*W-1:W]} + (r_prod[0] ? {1'b0, r_a} : {(W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_prod <= {{W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_prod <= {w_sum, r_prod[W-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_product = r_prod;

endmodule

// ===== hdl/hmib_div.sv =====
module hmib_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  hmib_pkg::t_div_cmd           i_cmd,
    input  logic [hmib_pkg::DIV_N-1:0]   i_dividend,
    input  logic [hmib_pkg::DIV_D-1:0]   i_divisor,
    output logic                         o_done,
    output logic [hmib_pkg::DIV_N-1:0]   o_quotient
);

    localparam int N  = hmib_pkg::DIV_N;
    localparam int D  = hmib_pkg::DIV_D;
    localparam int CW = hmib_pkg::DIV_CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_last;
    logic [D-1:0]  r_div;
    logic [D-1:0]  r_rem;
    logic [N-1:0]  r_quo;
    logic [D:0]    w_shift;
    logic          w_fit;

    // dividend bits leave the top of r_quo while quotient bits enter at the bottom
    assign w_shift = {r_rem, r_quo[N-1]};
    assign w_fit   = (w_shift >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == r_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_last <= i_cmd.steps - 1'b1;
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quo  <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_fit ? D'(w_shift - {1'b0, r_div}) : w_shift[D-1:0];
            r_quo <= {r_quo[N-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/hmib_sqrt.sv =====
module hmib_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [2*hmib_pkg::SQRT_W-1:0] i_radicand,
    output logic                          o_done,
    output logic [hmib_pkg::SQRT_W-1:0]   o_root
);

    localparam int W  = hmib_pkg::SQRT_W;
    localparam int CW = $clog2(W);

    logic           r_busy;
    logic           r_done;
    logic [CW-1:0]  r_cnt;
    logic [2*W-1:0] r_rad;
    logic [W+1:0]   r_rem;
    logic [W-1:0]   r_root;
    logic [W+1:0]   w_rem2;
    logic [W+1:0]   w_trial;
    logic           w_fit;

    // two radicand bits per cycle, one root bit out
    assign w_rem2  = {r_rem[W-1:0], r_rad[2*W-1:2*W-2]};
    assign w_trial = {r_root, 2'b01};
    assign w_fit   = (w_rem2 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*W-3:0], 2'b00};
            r_rem  <= w_fit ? (w_rem2 - w_trial) : w_rem2;
            r_root <= {r_root[W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hdl/hyperbolic_moveout_index_builder_core.sv =====
// Hyperbolic moveout index builder: each input beat is one grid point (time, offset and
// slowness index with t, h and v^2); each output beat gives its status and, for an
// accepted point, the data index, model index, travel sample and running entry number.
// Travel time sqrt(t^2 + 4h^2/v^2) is formed bit-serially: two 32-step shift-add
// multipliers run side by side, a shared restoring divider takes 64 steps for h^2/v^2
// and 34 steps for the final rounding divide by dt, and the root takes 32 steps.
// A valid point runs from MUL through CHK (or from SUM to FIN on overflow) before the
// next input beat; one failing the index, velocity or interval checks goes to FIN.
// A finished result waits in the output register while the next point is taken.
// Registers sit at byte addresses 0 (sample count), 4 (sample interval), 8 (start sample).
`include "hyperbolic_moveout_index_builder_core_defines.svh"

module hyperbolic_moveout_index_builder_core #(
    parameter int MAX_SAMPLES    = 4096,
    parameter int MAX_OFFSETS    = 512,
    parameter int MAX_SLOWNESSES = 512
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time_index[11:0], offset_index[20:12], slowness_index[29:21], sample_time[61:30],
    // offset_value[93:62], velocity_squared[125:94], zero[127:126]
    input  logic [127:0] s_axis_tdata,
    // restart[0]
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // data_index[20:0], model_index[41:21], entry_number[72:42], travel_sample[84:73],
    // zero[87:85]
    output logic [87:0]  m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL  = 8'b0000_0010,
        ST_DIV1 = 8'b0000_0100,
        ST_SUM  = 8'b0000_1000,
        ST_SQRT = 8'b0001_0000,
        ST_DIV2 = 8'b0010_0000,
        ST_CHK  = 8'b0100_0000,
        ST_FIN  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [12:0] r_nt;
    logic [31:0] r_dt;
    logic [11:0] r_t0;
    logic        w_cfg_wr;
    logic [12:0] w_nt_wr;

    // point held while it is worked on
    logic [11:0]       r_it;
    logic [8:0]        r_ih;
    logic [8:0]        r_iq;
    logic [31:0]       r_v2;
    hmib_pkg::t_status r_status;
    logic [11:0]       r_travel;
    logic [30:0]       r_entry;

    // output register
    logic              r_m_valid;
    hmib_pkg::t_status r_m_status;
    logic [20:0]       r_m_data_idx;
    logic [20:0]       r_m_model_idx;
    logic [30:0]       r_m_entry;
    logic [11:0]       r_m_travel;

    logic [11:0] w_it;
    logic [8:0]  w_ih;
    logic [8:0]  w_iq;
    logic [31:0] w_t;
    logic [31:0] w_h;
    logic [31:0] w_v2;
    logic [31:0] w_mag;
    logic        w_accept;
    hmib_pkg::t_status w_pre;

    logic        w_mul_a_done;
    logic        w_mul_b_done;
    logic [63:0] w_tt;
    logic [63:0] w_hh;
    hmib_pkg::t_div_cmd w_div_cmd;
    logic [63:0] w_div_dividend;
    logic [32:0] w_div_divisor;
    logic        w_div_done;
    logic [63:0] w_div_quo;
    logic        w_sqrt_start;
    logic        w_sqrt_done;
    logic [31:0] w_root;
    logic [64:0] w_sum;
    logic        w_sum_bad;
    logic [33:0] w_num;
    logic        w_out_free;
    logic [21:0] w_data_idx;
    logic [21:0] w_model_idx;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign w_nt_wr  = (32'(pwdata[12:0]) > 32'(MAX_SAMPLES)) ? 13'(MAX_SAMPLES) : pwdata[12:0];

    always_comb begin
        case (paddr[3:2])
            hmib_pkg::REG_SAMPLE_COUNT:    prdata = {19'b0, r_nt};
            hmib_pkg::REG_SAMPLE_INTERVAL: prdata = r_dt;
            hmib_pkg::REG_START_SAMPLE:    prdata = {20'b0, r_t0};
            default:                       prdata = 32'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nt <= 13'd1024;
            r_dt <= 32'd262;
            r_t0 <= 12'd0;
        end else if (w_cfg_wr) begin
            case (paddr[3:2])
                hmib_pkg::REG_SAMPLE_COUNT:    r_nt <= w_nt_wr;
                hmib_pkg::REG_SAMPLE_INTERVAL: r_dt <= pwdata;
                hmib_pkg::REG_START_SAMPLE:    r_t0 <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    assign w_it  = s_axis_tdata[11:0];
    assign w_ih  = s_axis_tdata[20:12];
    assign w_iq  = s_axis_tdata[29:21];
    assign w_t   = s_axis_tdata[61:30];
    assign w_h   = s_axis_tdata[93:62];
    assign w_v2  = s_axis_tdata[125:94];
    // the most negative offset maps onto itself, which is its magnitude as unsigned
    assign w_mag = w_h[31] ? (~w_h + 32'd1) : w_h;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    always_comb begin
        if (w_it < r_t0) begin
            w_pre = hmib_pkg::STAT_BEFORE;
        end else if (({1'b0, w_it} >= r_nt) || (32'(w_ih) >= 32'(MAX_OFFSETS)) ||
                     (32'(w_iq) >= 32'(MAX_SLOWNESSES))) begin
            w_pre = hmib_pkg::STAT_BEYOND;
        end else if ((w_v2 == 32'd0) || (r_dt == 32'd0)) begin
            w_pre = hmib_pkg::STAT_INVALID;
        end else begin
            w_pre = hmib_pkg::STAT_OK;
        end
    end

    hmib_mul u_mul_t (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_a       (w_t),
        .i_b       (w_t),
        .o_done    (w_mul_a_done),
        .o_product (w_tt)
    );

    hmib_mul u_mul_h (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_a       (w_mag),
        .i_b       (w_mag),
        .o_done    (w_mul_b_done),
        .o_product (w_hh)
    );

    // 2T + dt, placed at the top of the dividend so only its 34 bits are stepped
    assign w_num = {1'b0, w_root, 1'b0} + {2'b0, r_dt};

    always_comb begin
        w_div_cmd.start = ((r_state == ST_MUL) && w_mul_a_done) ||
                          ((r_state == ST_SQRT) && w_sqrt_done);
        if (r_state == ST_MUL) begin
            w_div_cmd.steps = hmib_pkg::DIV_LONG_STEPS;
            w_div_dividend  = w_hh;
            w_div_divisor   = {1'b0, r_v2};
        end else begin
            w_div_cmd.steps = hmib_pkg::DIV_SHORT_STEPS;
            w_div_dividend  = {w_num, {hmib_pkg::DIV_SHORT_SHIFT{1'b0}}};
            w_div_divisor   = {r_dt, 1'b0};
        end
    end

    hmib_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_div_cmd),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // t^2 + 4 h^2/v^2 with both overflow cases
    assign w_sum        = {1'b0, w_tt} + {1'b0, w_div_quo[61:0], 2'b00};
    assign w_sum_bad    = (w_div_quo[63:62] != 2'b00) || w_sum[64];
    assign w_sqrt_start = (r_state == ST_SUM) && !w_sum_bad;

    hmib_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_sqrt_start),
        .i_radicand (w_sum[63:0]),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    assign w_out_free  = !r_m_valid || m_axis_tready;
    assign w_data_idx  = 22'(r_ih) * 22'(r_nt) + 22'(r_travel);
    assign w_model_idx = 22'(r_iq) * 22'(r_nt) + 22'(r_it);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_pre == hmib_pkg::STAT_OK) ? ST_MUL : ST_FIN;
                end
            end
            ST_MUL: begin
                if (w_mul_a_done) n_state = ST_DIV1;
            end
            ST_DIV1: begin
                if (w_div_done) n_state = ST_SUM;
            end
            ST_SUM: begin
                n_state = w_sum_bad ? ST_FIN : ST_SQRT;
            end
            ST_SQRT: begin
                if (w_sqrt_done) n_state = ST_DIV2;
            end
            ST_DIV2: begin
                if (w_div_done) n_state = ST_CHK;
            end
            ST_CHK: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_entry   <= 31'd0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && s_axis_tuser[0]) begin
                r_entry <= 31'd0;
            end else if ((r_state == ST_FIN) && w_out_free &&
                         (r_status == hmib_pkg::STAT_OK)) begin
                r_entry <= r_entry + 31'd1;
            end
            if ((r_state == ST_FIN) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_it     <= w_it;
            r_ih     <= w_ih;
            r_iq     <= w_iq;
            r_v2     <= w_v2;
            r_status <= w_pre;
            r_travel <= 12'd0;
        end
        if ((r_state == ST_SUM) && w_sum_bad) begin
            r_status <= hmib_pkg::STAT_INVALID;
        end
        if (r_state == ST_CHK) begin
            r_travel <= w_div_quo[11:0];
            if (w_div_quo[33:0] >= 34'(r_nt)) begin
                r_status <= hmib_pkg::STAT_BEYOND;
            end
        end
        if ((r_state == ST_FIN) && w_out_free) begin
            r_m_status <= r_status;
            r_m_entry  <= r_entry;
            if (r_status == hmib_pkg::STAT_OK) begin
                r_m_data_idx  <= w_data_idx[20:0];
                r_m_model_idx <= w_model_idx[20:0];
                r_m_travel    <= r_travel;
            end else begin
                r_m_data_idx  <= 21'd0;
                r_m_model_idx <= 21'd0;
                r_m_travel    <= 12'd0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {3'b000, r_m_travel, r_m_entry, r_m_model_idx, r_m_data_idx};

    `HMIB_ASSERT(a_mul_lockstep, w_mul_a_done == w_mul_b_done, "multipliers out of step")
    `HMIB_ASSERT(a_div_owner, !w_div_done || (r_state == ST_DIV1) || (r_state == ST_DIV2), "divider finished outside a divide state")
    `HMIB_ASSERT_NEXT(a_accept_busy, w_accept, r_state != ST_IDLE, "point taken but sequencer stayed idle")
    `HMIB_ASSERT(a_ok_in_record, !(r_m_valid && (r_m_status == hmib_pkg::STAT_OK)) || ({1'b0, r_m_travel} < r_nt), "accepted beat with travel sample outside record")

endmodule

// ===== tb/sv/hyperbolic_moveout_index_builder_core_test.sv =====
module hyperbolic_moveout_index_builder_core_test;

    localparam int MAX_OFFSETS    = 512;
    localparam int MAX_SLOWNESSES = 512;
    localparam int SAMPLE_CAP     = 4096;

    typedef struct {
        logic [11:0] it;
        logic [8:0]  ih;
        logic [8:0]  iq;
        logic [31:0] t;
        logic [31:0] h;
        logic [31:0] v2;
        logic        restart;
    } t_grid_point;

    typedef struct {
        hmib_pkg::t_status status;
        logic [20:0]       data_index;
        logic [20:0]       model_index;
        logic [30:0]       entry_number;
        logic [11:0]       travel_sample;
    } t_moveout_entry;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} t_rx_mode;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;
    logic [0:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [87:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // register mirror and entry counter of the predictor
    logic [12:0]  nt_shadow = 13'd1024;
    logic [31:0]  dt_shadow = 32'd262;
    logic [11:0]  start_shadow = 12'd0;
    logic [30:0]  entry_tally = '0;

    t_moveout_entry pending_entries[$];
    int           fail_count = 0;
    int           burst_left = 0;
    bit           tx_bursty = 1'b1;
    t_rx_mode     rx_mode = RX_RANDOM;
    int           rx_hold_cycles = 0;
    int           rx_tick = 0;

    hyperbolic_moveout_index_builder_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] floor_sqrt(input logic [63:0] radicand);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if ({32'd0, trial} * {32'd0, trial} <= radicand)
                root = trial;
        end
        return root;
    endfunction

    function automatic t_moveout_entry predict_moveout(input t_grid_point p);
        t_moveout_entry r;
        logic [31:0] h_mag;
        logic [63:0] t_sq;
        logic [63:0] h_term;
        logic [64:0] radicand;
        logic [63:0] travel;
        r.status = hmib_pkg::STAT_OK;
        r.data_index = '0;
        r.model_index = '0;
        r.travel_sample = '0;
        travel = '0;
        if (p.restart)
            entry_tally = '0;
        if (p.it < start_shadow) begin
            r.status = hmib_pkg::STAT_BEFORE;
        end else if (p.it >= nt_shadow || p.ih >= MAX_OFFSETS || p.iq >= MAX_SLOWNESSES) begin
            r.status = hmib_pkg::STAT_BEYOND;
        end else if (p.v2 == 0 || dt_shadow == 0) begin
            r.status = hmib_pkg::STAT_INVALID;
        end else begin
            h_mag = p.h[31] ? -p.h : p.h;
            t_sq = {32'd0, p.t} * {32'd0, p.t};
            h_term = ({32'd0, h_mag} * {32'd0, h_mag}) / {32'd0, p.v2};
            if (h_term > 64'h3FFF_FFFF_FFFF_FFFF) begin
                r.status = hmib_pkg::STAT_INVALID;
            end else begin
                radicand = {1'b0, t_sq} + {1'b0, h_term[61:0], 2'b00};
                if (radicand[64]) begin
                    r.status = hmib_pkg::STAT_INVALID;
                end else begin
                    // round half up of T/dt
                    travel = ({31'd0, floor_sqrt(radicand[63:0]), 1'b0} + {32'd0, dt_shadow})
                             / {31'd0, dt_shadow, 1'b0};
                    if (travel >= nt_shadow)
                        r.status = hmib_pkg::STAT_BEYOND;
                end
            end
        end
        r.entry_number = entry_tally;
        if (r.status == hmib_pkg::STAT_OK) begin
            r.data_index = 21'(p.ih * nt_shadow + travel);
            r.model_index = 21'(32'(p.iq) * 32'(nt_shadow) + 32'(p.it));
            r.travel_sample = travel[11:0];
            entry_tally = entry_tally + 31'd1;
        end
        return r;
    endfunction

    function automatic t_grid_point pt(input logic [11:0] it, input logic [8:0] ih,
                                       input logic [8:0] iq, input logic [31:0] t,
                                       input logic [31:0] h, input logic [31:0] v2,
                                       input logic restart);
        t_grid_point p;
        p.it = it;
        p.ih = ih;
        p.iq = iq;
        p.t = t;
        p.h = h;
        p.v2 = v2;
        p.restart = restart;
        return p;
    endfunction

    function automatic t_grid_point random_point();
        t_grid_point p;
        int unsigned lo;
        int unsigned hi;
        p.ih = 9'($urandom);
        p.iq = 9'($urandom);
        p.restart = ($urandom_range(0, 24) == 0);
        if ($urandom_range(0, 9) < 7) begin
            // consistent grid point: t follows the time index, realistic h and v^2
            lo = start_shadow;
            hi = (nt_shadow == 0) ? 0 : nt_shadow - 1;
            p.it = (lo <= hi) ? 12'($urandom_range(lo, hi)) : 12'($urandom);
            p.t = 32'(p.it * dt_shadow) + 32'($urandom_range(0, 3));
            p.h = 32'($urandom_range(0, 3000 * 65536));
            if ($urandom_range(0, 1))
                p.h = -p.h;
            p.v2 = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, 5000))
                                                : 32'($urandom_range(1_000_000, 25_000_000));
        end else begin
            p.it = 12'($urandom);
            p.t = $urandom;
            p.h = $urandom;
            p.v2 = $urandom;
            case ($urandom_range(0, 5))
                0: p.v2 = '0;
                1: p.h = 32'h8000_0000;
                2: p.t = 32'hFFFF_FFFF;
                3: p.v2 = 32'd1;
                default: ;
            endcase
        end
        return p;
    endfunction

    task automatic send_point(input t_grid_point p);
        int gap;
        gap = 0;
        if (tx_bursty) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap = $urandom_range(1, 10);
            end
            burst_left--;
        end
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, p.v2, p.h, p.t, p.iq, p.ih, p.it};
        s_axis_tuser  <= p.restart;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_entries.push_back(predict_moveout(p));
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_entries.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hmib_pkg::REG_SAMPLE_COUNT:
                nt_shadow = (value[12:0] > SAMPLE_CAP) ? 13'(SAMPLE_CAP) : value[12:0];
            hmib_pkg::REG_SAMPLE_INTERVAL: dt_shadow = value;
            hmib_pkg::REG_START_SAMPLE:    start_shadow = value[11:0];
            default: ;
        endcase
    endtask

    task automatic set_registers(input logic [31:0] nt, input logic [31:0] dt,
                                 input logic [31:0] t0);
        wait_drained();
        repeat (4) @(posedge i_clk);
        write_register(hmib_pkg::REG_SAMPLE_COUNT, nt);
        write_register(hmib_pkg::REG_SAMPLE_INTERVAL, dt);
        write_register(hmib_pkg::REG_START_SAMPLE, t0);
    endtask

    // reset values: nt 1024, dt 262, start 0
    task automatic test_directed_points();
        send_point(pt(12'd0, 9'd0, 9'd0, 32'd0, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd100, 9'd5, 9'd7, 32'd26200, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd200, 9'd511, 9'd511, 32'd52400, -(32'd1000 << 16),
                      32'd4_000_000, 1'b0));
        // most negative offset with unit velocity overflows 4*h^2/v^2
        send_point(pt(12'd10, 9'd1, 9'd1, 32'd0, 32'h8000_0000, 32'd1, 1'b0));
        send_point(pt(12'd10, 9'd1, 9'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1, 1'b0));
        send_point(pt(12'd10, 9'd1, 9'd1, 32'd0, 32'h7FFF_FFFF, 32'd1, 1'b0));
        send_point(pt(12'd10, 9'd2, 9'd3, 32'd2620, 32'h0001_0000, 32'd0, 1'b0));
        send_point(pt(12'd10, 9'd2, 9'd3, 32'd2620, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0));
        send_point(pt(12'd1023, 9'd3, 9'd4, 32'd268026, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd1023, 9'd3, 9'd4, 32'd268288, 32'd0, 32'd1, 1'b0));
        // exactly half a sample rounds up, just below rounds down
        send_point(pt(12'd1, 9'd0, 9'd0, 32'd131, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd1, 9'd0, 9'd0, 32'd130, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd4095, 9'd0, 9'd0, 32'd0, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd5, 9'd6, 9'd8, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd20, 9'd9, 9'd9, 32'd5240, 32'h0100_0000, 32'd9_000_000, 1'b1));
    endtask

    task automatic test_register_extremes();
        set_registers(32'd4096, 32'd262, 32'd4095);
        send_point(pt(12'd4094, 9'd1, 9'd1, 32'd0, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd4095, 9'd511, 9'd511, 32'd1_072_890, 32'd0, 32'd1, 1'b0));
        // oversized sample count is held at the cap
        set_registers(32'h0000_1FFF, 32'd0, 32'd0);
        send_point(pt(12'd5, 9'd1, 9'd1, 32'd100, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd4095, 9'd2, 9'd2, 32'd100, 32'd0, 32'd1, 1'b0));
        set_registers(32'd2, 32'hFFFF_FFFF, 32'd0);
        send_point(pt(12'd1, 9'd4, 9'd4, 32'hFFFF_FFFF, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd0, 9'd4, 9'd4, 32'd0, 32'd0, 32'd1, 1'b0));
        send_point(pt(12'd2, 9'd4, 9'd4, 32'd0, 32'd0, 32'd1, 1'b0));
    endtask

    task automatic test_random_points(input int count);
        repeat (count) send_point(random_point());
    endtask

    // output side held off long enough for the core to stall its input
    task automatic test_output_backpressure();
        wait_drained();
        tx_bursty = 1'b0;
        rx_hold_cycles = 1200;
        test_random_points(16);
        tx_bursty = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        test_random_points(10);
        wait_drained();
        test_random_points(10);
    endtask

    initial begin : rx_side
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_axis_tready <= 1'b0;
            end else begin
                rx_tick++;
                case (rx_mode)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
                    default:   m_axis_tready <= (rx_tick % 7 != 3) && (rx_tick % 7 != 4);
                endcase
            end
        end
    end

    function automatic void check_field(input string fname, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_moveout_entry want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_entries.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected beat, expected none, actual status %0d data %h",
                         $time, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_entries.pop_front();
                check_field("status", want.status, m_axis_tuser);
                check_field("data_index", want.data_index, m_axis_tdata[20:0]);
                check_field("model_index", want.model_index, m_axis_tdata[41:21]);
                check_field("entry_number", want.entry_number, m_axis_tdata[72:42]);
                check_field("travel_sample", want.travel_sample, m_axis_tdata[84:73]);
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        rx_mode = RX_RANDOM;
        test_directed_points();
        test_register_extremes();

        set_registers(32'd1024, 32'd262, 32'd0);
        rx_mode = RX_ALWAYS;
        tx_bursty = 1'b0;
        test_random_points(150);

        set_registers(32'd4096, 32'd131, 32'd100);
        rx_mode = RX_PATTERN;
        tx_bursty = 1'b1;
        test_random_points(150);

        set_registers(32'd300, 32'd655, 32'd17);
        rx_mode = RX_RANDOM;
        test_random_points(150);

        test_output_backpressure();
        test_pause_until_drained();

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hmib_pkg.sv
hdl/hmib_mul.sv
hdl/hmib_div.sv
hdl/hmib_sqrt.sv
hdl/hyperbolic_moveout_index_builder_core.sv
tb/sv/hyperbolic_moveout_index_builder_core_test.sv
